// ===== sv/ssq_pkg.sv =====
// types, codes and constants shared by the sorted sleep/wakeup queue modules
package ssq_pkg;

  localparam int TICK_BITS     = 63;
  localparam int DUR_BITS      = 32;
  localparam int ID_FIELD_BITS = 8;

  // command codes of a request
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SLEEP = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_WOKEN  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // one request transfer
  typedef struct packed {
    logic                     command;
    logic [ID_FIELD_BITS-1:0] sleeper_id;
    logic [DUR_BITS-1:0]      sleep_duration;
  } request_t;

  // one result transfer
  typedef struct packed {
    kind_t                    kind;
    logic [ID_FIELD_BITS-1:0] woken_id;
    logic [TICK_BITS-1:0]     current_tick;
    logic                     last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic insert;
    logic emit_full;
    logic emit_none;
    logic emit_wake;
  } ssq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic head_due;
    logic more_due;
    logic out_free;
  } ssq_status_t;

endpackage

// ===== sv/sorted_sleep_wakeup_queue.sv =====
// top level of the sorted sleep/wakeup queue
//
// A request channel (request_valid, request_stall, request_data) takes tick
// and sleep commands; a result channel (result_valid, result_stall,
// result_data) returns results. A transfer happens on a rising edge with
// valid high and stall low.
// A sleep request adds the sleeper at tick_count + duration (saturated),
// behind entries with equal wake times, and gives one accept result, or a
// full result when all QUEUE_DEPTH entries are taken.
// A tick advances the count and gives one woken result per due sleeper,
// front first, last marked, or one plain tick result when nobody is due.
// A request is accepted in the idle state; its results then go one by one
// into the result register, one queue head per cycle for a tick that wakes
// sleepers while the receiver does not stall.
// The sorted entries are a row of registers compared in parallel on insert.
// Reset clears the tick count, the fill count and the result valid flag.
// While the receiver stalls, the result register holds its item and the
// block waits before loading the next result; request_stall stays high
// until the final result of the current request is in the result register.
module sorted_sleep_wakeup_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  ssq_pkg::request_t request_data,
  output logic              result_valid,
  input  logic              result_stall,
  output ssq_pkg::result_t  result_data
);

  ssq_pkg::ssq_cmd_t    cmd;
  ssq_pkg::ssq_status_t status;

  // controller
  ssq_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .request_valid   (request_valid),
    .request_command (request_data.command),
    .status          (status),
    .cmd             (cmd),
    .request_stall   (request_stall)
  );

  // datapath
  ssq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request_data (request_data),
    .cmd          (cmd),
    .status       (status),
    .result_data  (result_data),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

// ===== sv/ssq_ctrl.sv =====
// controller state machine of the sorted sleep/wakeup queue
module ssq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  input  logic                 request_command,
  input  ssq_pkg::ssq_status_t status,
  output ssq_pkg::ssq_cmd_t    cmd,
  output logic                 request_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLEEP,
    S_TICK
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (request_valid) begin
          cmd.accept = 1'b1;
          state_next = (request_command == ssq_pkg::CMD_SLEEP) ? S_SLEEP : S_TICK;
        end
      end
      S_SLEEP: begin
        if (status.out_free) begin
          if (status.full) begin
            cmd.emit_full = 1'b1;
          end else begin
            cmd.insert = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (status.out_free) begin
          if (status.head_due) begin
            cmd.emit_wake = 1'b1;
            if (!status.more_due) begin
              state_next = S_IDLE;
            end
          end else begin
            cmd.emit_none = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      request_stall <= 1'b0;
    end else begin
      state         <= state_next;
      request_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== sv/ssq_datapath.sv =====
// datapath of the sorted sleep/wakeup queue: tick count, sorted entries, result register
module ssq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ssq_pkg::request_t    request_data,
  input  ssq_pkg::ssq_cmd_t    cmd,
  output ssq_pkg::ssq_status_t status,
  output ssq_pkg::result_t     result_data,
  output logic                 result_valid,
  input  logic                 result_stall
);

  localparam int TB        = ssq_pkg::TICK_BITS;
  localparam int IFB       = ssq_pkg::ID_FIELD_BITS;
  localparam int OCC_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int KEEP_BITS = (ID_BITS < IFB) ? ID_BITS : IFB;
  localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(QUEUE_DEPTH);

  logic [TB-1:0]        tick_count;
  logic [OCC_BITS-1:0]  occupancy;
  logic [TB-1:0]        wake_time [QUEUE_DEPTH];
  logic [KEEP_BITS-1:0] queued_id [QUEUE_DEPTH];
  logic [TB-1:0]        new_wake;
  logic [KEEP_BITS-1:0] new_id;
  logic [TB:0]          wake_sum;
  logic [TB-1:0]        wake_sat;
  logic [QUEUE_DEPTH-1:0] stays;
  logic [IFB-1:0]       new_id_ext;
  logic [IFB-1:0]       head_id_ext;
  logic                 load;
  ssq_pkg::result_t     result_next;

  // saturating wake time from the current count
  assign wake_sum = {1'b0, tick_count} + (TB + 1)'(request_data.sleep_duration);
  assign wake_sat = wake_sum[TB] ? {TB{1'b1}} : wake_sum[TB-1:0];

  // latch the accepted request, advance the count on a tick
  always_ff @(posedge clk) begin
    if (cmd.accept && (request_data.command == ssq_pkg::CMD_SLEEP)) begin
      new_wake <= wake_sat;
      new_id   <= request_data.sleeper_id[KEEP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (cmd.accept && (request_data.command == ssq_pkg::CMD_TICK)) begin
      tick_count <= tick_count + TB'(1);
    end
  end

  // entries that keep their place on insert (sorted, so a prefix)
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
    assign stays[g] = (occupancy > OCC_BITS'(g)) && (wake_time[g] <= new_wake);
  end

  // per-entry insert and pop shifting
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert && !stays[0]) begin
          wake_time[0] <= new_wake;
          queued_id[0] <= new_id;
        end else if (cmd.emit_wake) begin
          wake_time[0] <= wake_time[1];
          queued_id[0] <= queued_id[1];
        end
      end
    end else if (g == QUEUE_DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.insert && !stays[g]) begin
          wake_time[g] <= stays[g-1] ? new_wake : wake_time[g-1];
          queued_id[g] <= stays[g-1] ? new_id : queued_id[g-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.insert && !stays[g]) begin
          wake_time[g] <= stays[g-1] ? new_wake : wake_time[g-1];
          queued_id[g] <= stays[g-1] ? new_id : queued_id[g-1];
        end else if (cmd.emit_wake) begin
          wake_time[g] <= wake_time[g+1];
          queued_id[g] <= queued_id[g+1];
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.insert) begin
      occupancy <= occupancy + OCC_BITS'(1);
    end else if (cmd.emit_wake) begin
      occupancy <= occupancy - OCC_BITS'(1);
    end
  end

  // status toward the controller
  assign status.full     = (occupancy == OCC_FULL);
  assign status.head_due = (occupancy != '0) && (wake_time[0] <= tick_count);
  assign status.more_due = (occupancy > OCC_BITS'(1)) && (wake_time[1] <= tick_count);
  assign status.out_free = !result_valid || !result_stall;

  // zero-extended ids
  always_comb begin
    new_id_ext                   = '0;
    new_id_ext[KEEP_BITS-1:0]    = new_id;
    head_id_ext                  = '0;
    head_id_ext[KEEP_BITS-1:0]   = queued_id[0];
  end

  // result selection
  assign load = cmd.insert || cmd.emit_full || cmd.emit_none || cmd.emit_wake;

  always_comb begin
    result_next.current_tick = tick_count;
    result_next.last         = 1'b1;
    result_next.woken_id     = '0;
    result_next.kind         = ssq_pkg::KIND_NONE;
    if (cmd.insert) begin
      result_next.kind     = ssq_pkg::KIND_ACCEPT;
      result_next.woken_id = new_id_ext;
    end else if (cmd.emit_full) begin
      result_next.kind = ssq_pkg::KIND_FULL;
    end else if (cmd.emit_wake) begin
      result_next.kind     = ssq_pkg::KIND_WOKEN;
      result_next.woken_id = head_id_ext;
      result_next.last     = !status.more_due;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_FULL)
    else $error("fill count beyond queue depth");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (occupancy != OCC_FULL))
    else $error("insert into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_wake |-> (occupancy != '0) && (wake_time[0] <= tick_count))
    else $error("wake of an entry that is not due");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> occupancy == OCC_BITS'($past(occupancy) + OCC_BITS'(1)))
    else $error("fill count did not advance on insert");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (occupancy > OCC_BITS'(1)) |-> (wake_time[0] <= wake_time[1]))
    else $error("queue head out of order");

  a_no_load_blocked: assert property (@(posedge clk) disable iff (rst)
    load |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");
`endif

endmodule
